// ===== src/itrs_pkg.sv =====
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types, constants and the checkerboard sweep table for the idle
// tile refresh scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package itrs_pkg;

    localparam int TILE_COUNT = 16;
    localparam int SWEEP_W    = $clog2(TILE_COUNT);
    localparam int TIME_W     = 64;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int COORD_W    = 10;

    localparam logic [COORD_W-1:0] TILE_W = 10'd150;
    localparam logic [COORD_W-1:0] TILE_H = 10'd200;

    localparam logic [CFG_W-1:0] IDLE_THRESHOLD_RESET = 32'd60000;
    localparam logic [CFG_W-1:0] STEP_INTERVAL_RESET  = 32'd500;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL  = 8'd1;

    // item codes; code 3 is reserved and ignored
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ACTIVITY = 2'd1,
        MODE_DISABLE  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] idle_threshold;
        logic [CFG_W-1:0] step_interval;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } box_t;

    typedef struct packed {
        logic                refresh_now;
        box_t                box;
        logic                is_enabled;
        logic [SWEEP_W-1:0]  sweep_position;
    } result_t;

    // even tiles (col + row even) first, then the odd ones
    function automatic logic [SWEEP_W-1:0] sweep_tile(input logic [SWEEP_W-1:0] pos);
        logic [SWEEP_W-1:0] tile;
        begin
            case (pos)
                4'd0:    tile = 4'd0;
                4'd1:    tile = 4'd2;
                4'd2:    tile = 4'd5;
                4'd3:    tile = 4'd7;
                4'd4:    tile = 4'd8;
                4'd5:    tile = 4'd10;
                4'd6:    tile = 4'd13;
                4'd7:    tile = 4'd15;
                4'd8:    tile = 4'd1;
                4'd9:    tile = 4'd3;
                4'd10:   tile = 4'd4;
                4'd11:   tile = 4'd6;
                4'd12:   tile = 4'd9;
                4'd13:   tile = 4'd11;
                4'd14:   tile = 4'd12;
                default: tile = 4'd14;
            endcase
            return tile;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/idle_tile_refresh_scheduler.sv =====
// ----------------------------------------------------------------------------
// idle_tile_refresh_scheduler
// Idle-time checkerboard tile refresh scheduler for a 600x800 panel in a
// 4x4 grid. Input register, combinational decision, result register.
// ----------------------------------------------------------------------------
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid/in_ready, mode, now_ms,           | to block
//           | update_refused                             |
//   out     | out_valid/out_ready, refresh_now, box_*,   | from block
//           | is_enabled, sweep_position                 |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | to block
//
// One item per cycle sustained while the output is not stalled; each item
// passes the input register, then the 64-bit due compare/add into the
// result register. Reset restores threshold 60000, interval 500, enabled,
// sweep position 0, due time 0. A stalled output holds its result while a
// new item still fills the input register; the input stalls only when both
// registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_tile_refresh_scheduler
    import itrs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           mode,
    input  wire logic [TIME_W-1:0]    now_ms,
    input  wire logic                 update_refused,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      refresh_now,
    output logic [COORD_W-1:0]        box_left,
    output logic [COORD_W-1:0]        box_top,
    output logic [COORD_W-1:0]        box_right,
    output logic [COORD_W-1:0]        box_bottom,
    output logic                      is_enabled,
    output logic [SWEEP_W-1:0]        sweep_position,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    cfg_t              cfg;
    result_t           result;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [1:0]        mode_reg;
    logic [TIME_W-1:0] now_reg;
    logic              refused_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           result_reg;

    logic              advance;
    logic              step;
    logic              in_xfer;

    itrs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    itrs_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .mode           (mode_reg),
        .now_ms         (now_reg),
        .update_refused (refused_reg),
        .cfg            (cfg),
        .result         (result)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg    <= mode;
            now_reg     <= now_ms;
            refused_reg <= update_refused;
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign refresh_now    = result_reg.refresh_now;
    assign box_left       = result_reg.box.left;
    assign box_top        = result_reg.box.top;
    assign box_right      = result_reg.box.right;
    assign box_bottom     = result_reg.box.bottom;
    assign is_enabled     = result_reg.is_enabled;
    assign sweep_position = result_reg.sweep_position;

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    a_no_box_without_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.refresh_now |->
            result_reg.box.left == '0 && result_reg.box.bottom == '0)
        else $error("box bounds set without a refresh");

    a_input_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(now_reg))
        else $error("pending input item lost while output stalled");

endmodule

`default_nettype wire

// ===== src/itrs_cfg.sv =====
// ----------------------------------------------------------------------------
// itrs_cfg
// Configuration registers: idle threshold and step interval.
// ----------------------------------------------------------------------------
`default_nettype none

module itrs_cfg
    import itrs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDLE_THRESHOLD: cfg_next.idle_threshold = cfg_data;
                CFG_STEP_INTERVAL:  cfg_next.step_interval  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_threshold <= IDLE_THRESHOLD_RESET;
            cfg_reg.step_interval  <= STEP_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/itrs_tile_map.sv =====
// ----------------------------------------------------------------------------
// itrs_tile_map
// Maps a sweep position to the pixel bounding box of its tile.
// ----------------------------------------------------------------------------
`default_nettype none

module itrs_tile_map
    import itrs_pkg::*;
(
    input  wire logic [SWEEP_W-1:0] sweep_position,
    output box_t                    box
);

    logic [SWEEP_W-1:0] tile;
    logic [1:0]         col;
    logic [1:0]         row;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;

    assign tile = sweep_tile(sweep_position);
    assign col  = tile[1:0];
    assign row  = tile[3:2];

    always_comb
    begin
        case (col)
            2'd0:    left = 10'd0;
            2'd1:    left = TILE_W;
            2'd2:    left = 10'(TILE_W * 2);
            default: left = 10'(TILE_W * 3);
        endcase
        case (row)
            2'd0:    top = 10'd0;
            2'd1:    top = TILE_H;
            2'd2:    top = 10'(TILE_H * 2);
            default: top = 10'(TILE_H * 3);
        endcase
    end

    assign box.left   = left;
    assign box.top    = top;
    assign box.right  = left + TILE_W - 10'd1;
    assign box.bottom = top + TILE_H - 10'd1;

endmodule

`default_nettype wire

// ===== src/itrs_core.sv =====
// ----------------------------------------------------------------------------
// itrs_core
// Scheduler state (due time, sweep position, enable) and the per-item
// decision: activity restart, disable, or a due tick that issues a tile or, if refused, disables.
// ----------------------------------------------------------------------------
`default_nettype none

module itrs_core
    import itrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [1:0]        mode,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic              update_refused,
    input  wire cfg_t              cfg,
    output result_t                result
);

    logic [TIME_W-1:0]  due_time_reg;
    logic [TIME_W-1:0]  due_time_next;
    logic [SWEEP_W-1:0] sweep_index_reg;
    logic [SWEEP_W-1:0] sweep_index_next;
    logic               active_reg;
    logic               active_next;

    box_t               tile_box;
    logic               is_due;
    logic               fire;
    logic [TIME_W-1:0]  due_idle;
    logic [TIME_W-1:0]  due_step;

    itrs_tile_map u_tile_map (
        .sweep_position (sweep_index_reg),
        .box            (tile_box)
    );

    assign is_due   = now_ms >= due_time_reg;
    assign due_idle = now_ms + {{(TIME_W-CFG_W){1'b0}}, cfg.idle_threshold};
    assign due_step = now_ms + {{(TIME_W-CFG_W){1'b0}}, cfg.step_interval};

    always_comb
    begin
        due_time_next    = due_time_reg;
        sweep_index_next = sweep_index_reg;
        active_next      = active_reg;
        fire             = 1'b0;
        case (mode)
            MODE_ACTIVITY:
            begin
                due_time_next    = due_idle;
                sweep_index_next = '0;
            end
            MODE_DISABLE:
            begin
                active_next = 1'b0;
            end
            MODE_TICK:
            begin
                if (active_reg && is_due)
                begin
                    if (update_refused)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        fire             = 1'b1;
                        sweep_index_next = sweep_index_reg + 1'b1;
                        // last tile of the sweep wraps to 0 and waits a full idle gap
                        if (&sweep_index_reg)
                            due_time_next = due_idle;
                        else
                            due_time_next = due_step;
                    end
                end
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.refresh_now    = fire;
        result.box            = fire ? tile_box : '0;
        result.is_enabled     = active_next;
        result.sweep_position = sweep_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_time_reg    <= '0;
            sweep_index_reg <= '0;
            active_reg      <= 1'b1;
        end
        else if (step)
        begin
            due_time_reg    <= due_time_next;
            sweep_index_reg <= sweep_index_next;
            active_reg      <= active_next;
        end
    end

    a_issue_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.refresh_now |-> active_reg && is_due)
        else $error("tile issued while disabled or not due");

    a_disable_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |=> !active_reg)
        else $error("scheduler re-enabled without reset");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(sweep_index_reg) && $stable(due_time_reg))
        else $error("state changed with no item in flight");

endmodule

`default_nettype wire

// ===== verif/tb_idle_tile_refresh_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_idle_tile_refresh_scheduler
// Self-checking bench for the idle tile refresh scheduler. A scoreboard class
// keeps its own copy of the sweep state and registers, predicts one result
// per accepted item and checks every output transfer against it in order.
// Stimulus: directed checkerboard sweep and wrap cases, then full sweeps with
// random timing under several register settings, then a disabled tail.
// ----------------------------------------------------------------------------
module tb_idle_tile_refresh_scheduler;
    import itrs_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 240;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_PRINTS    = 40;
    localparam int PIXELS_W      = 150;
    localparam int PIXELS_H      = 200;

    class refresh_scoreboard;
        logic [TIME_W-1:0]  due_at;
        logic [SWEEP_W-1:0] sweep_pos;
        logic               enabled;
        logic [CFG_W-1:0]   idle_gap;
        logic [CFG_W-1:0]   step_gap;
        result_t            expected_q[$];
        int                 errors;

        function new();
            due_at    = '0;
            sweep_pos = '0;
            enabled   = 1'b1;
            idle_gap  = 32'd60000;
            step_gap  = 32'd500;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_IDLE_THRESHOLD)
                idle_gap = data;
            else if (idx == CFG_STEP_INTERVAL)
                step_gap = data;
        endfunction

        // predict the result of one accepted item
        function void note_item(logic [1:0] kind, logic [TIME_W-1:0] stamp, logic refused);
            result_t    want;
            logic [1:0] row;
            logic [1:0] col;
            want = '0;
            if (kind == MODE_ACTIVITY) begin
                due_at    = stamp + {32'b0, idle_gap};
                sweep_pos = '0;
            end
            else if (kind == MODE_DISABLE) begin
                enabled = 1'b0;
            end
            else if (kind == MODE_TICK && enabled && stamp >= due_at) begin
                if (refused) begin
                    enabled = 1'b0;
                end
                else begin
                    // upper half of the sweep visits the odd tiles
                    row = sweep_pos[2:1];
                    col = {sweep_pos[0], sweep_pos[1] ^ sweep_pos[3]};
                    want.refresh_now = 1'b1;
                    want.box.left    = COORD_W'(col * PIXELS_W);
                    want.box.right   = COORD_W'(col * PIXELS_W + PIXELS_W - 1);
                    want.box.top     = COORD_W'(row * PIXELS_H);
                    want.box.bottom  = COORD_W'(row * PIXELS_H + PIXELS_H - 1);
                    if (sweep_pos == SWEEP_W'(TILE_COUNT - 1)) begin
                        sweep_pos = '0;
                        due_at    = stamp + {32'b0, idle_gap};
                    end
                    else begin
                        sweep_pos = sweep_pos + 1'b1;
                        due_at    = stamp + {32'b0, step_gap};
                    end
                end
            end
            want.is_enabled     = enabled;
            want.sweep_position = sweep_pos;
            expected_q.push_back(want);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.refresh_now !== want.refresh_now)
                report($sformatf("refresh_now %0b, want %0b", got.refresh_now,
                                 want.refresh_now));
            if (got.box.left !== want.box.left)
                report($sformatf("box_left %0d, want %0d", got.box.left, want.box.left));
            if (got.box.top !== want.box.top)
                report($sformatf("box_top %0d, want %0d", got.box.top, want.box.top));
            if (got.box.right !== want.box.right)
                report($sformatf("box_right %0d, want %0d", got.box.right,
                                 want.box.right));
            if (got.box.bottom !== want.box.bottom)
                report($sformatf("box_bottom %0d, want %0d", got.box.bottom,
                                 want.box.bottom));
            if (got.is_enabled !== want.is_enabled)
                report($sformatf("is_enabled %0b, want %0b", got.is_enabled,
                                 want.is_enabled));
            if (got.sweep_position !== want.sweep_position)
                report($sformatf("sweep_position %0d, want %0d", got.sweep_position,
                                 want.sweep_position));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           mode = MODE_TICK;
    logic [TIME_W-1:0]    now_ms = '0;
    logic                 update_refused = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 refresh_now;
    logic [COORD_W-1:0]   box_left;
    logic [COORD_W-1:0]   box_top;
    logic [COORD_W-1:0]   box_right;
    logic [COORD_W-1:0]   box_bottom;
    logic                 is_enabled;
    logic [SWEEP_W-1:0]   sweep_position;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    refresh_scoreboard sb = new();
    bit  calm = 1'b0;
    bit  hold_request = 1'b0;
    int  items_sent = 0;
    int  cycle_count = 0;

    idle_tile_refresh_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .now_ms         (now_ms),
        .update_refused (update_refused),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .refresh_now    (refresh_now),
        .box_left       (box_left),
        .box_top        (box_top),
        .box_right      (box_right),
        .box_bottom     (box_bottom),
        .is_enabled     (is_enabled),
        .sweep_position (sweep_position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("idle_tile_refresh_scheduler verification failed");
            $finish;
        end
    end

    // result side: check each transfer, then pick ready for the next cycle
    initial
    begin : result_sink
        result_t got;
        int      hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got.refresh_now    = refresh_now;
                got.box.left       = box_left;
                got.box.top        = box_top;
                got.box.right      = box_right;
                got.box.bottom     = box_bottom;
                got.is_enabled     = is_enabled;
                got.sweep_position = sweep_position;
                sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 36);
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [TIME_W-1:0] stamp,
                             input logic refused);
        int gap = 0;
        while (!calm && $urandom_range(99) < 36)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= kind;
        now_ms         <= stamp;
        update_refused <= refused;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(kind, stamp, refused);
        items_sent++;
    endtask

    // a refused flag on a due tick would disable the block for good
    function automatic logic safe_refusal(logic [TIME_W-1:0] stamp);
        return (stamp < sb.due_at) ? 1'($urandom_range(1)) : 1'b0;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] idle_val,
                                input logic [CFG_W-1:0] step_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDLE_THRESHOLD;
        cfg_data  <= idle_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(CFG_IDLE_THRESHOLD, idle_val);
        cfg_index <= CFG_STEP_INTERVAL;
        cfg_data  <= step_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(CFG_STEP_INTERVAL, step_val);
        cfg_valid <= 1'b0;
    endtask

    // activity, then one full checkerboard pass with stray early ticks
    task automatic run_sweep();
        logic [TIME_W-1:0] stamp;
        if ($urandom_range(4) == 0)
            stamp = {$urandom, $urandom};
        else
            stamp = sb.due_at - 64'($urandom_range(5000));
        send_item(MODE_ACTIVITY, stamp, 1'($urandom_range(1)));
        for (int k = 0; k < TILE_COUNT; k++) begin
            if ($urandom_range(3) == 0) begin
                stamp = sb.due_at - 64'($urandom_range(2000, 1));
                send_item(MODE_TICK, stamp, safe_refusal(stamp));
            end
            stamp = sb.due_at + 64'($urandom_range(3));
            send_item(MODE_TICK, stamp, safe_refusal(stamp));
        end
    endtask

    task automatic run_noise();
        logic [TIME_W-1:0] stamp;
        repeat (4) begin
            stamp = {$urandom, $urandom};
            case ($urandom_range(3))
                0: send_item(MODE_TICK, stamp, safe_refusal(stamp));
                1: send_item(MODE_ACTIVITY, stamp, 1'($urandom_range(1)));
                2: send_item(MODE_RESERVED, stamp, 1'($urandom_range(1)));
                default: begin
                    stamp = sb.due_at - 64'($urandom_range(3000, 1));
                    send_item(MODE_TICK, stamp, safe_refusal(stamp));
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        logic [TIME_W-1:0] stamp;
        logic [1:0]        kind;
        logic [CFG_W-1:0]  idle_val;
        logic [CFG_W-1:0]  step_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_item(MODE_TICK, 64'd0, 1'b0);
        send_item(MODE_TICK, 64'd499, 1'b1);
        send_item(MODE_TICK, 64'd500, 1'b0);
        send_item(MODE_RESERVED, '1, 1'b1);
        send_item(MODE_ACTIVITY, '1, 1'b0);     // due time wraps past 2^64
        send_item(MODE_TICK, 64'd59998, 1'b0);
        send_item(MODE_TICK, 64'd59999, 1'b0);
        // finish the sweep: every tile, last one rearms with the threshold
        repeat (TILE_COUNT - 1)
            send_item(MODE_TICK, sb.due_at, 1'b0);
        send_item(MODE_ACTIVITY, 64'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_val = '0; step_val = '0; end
                1: begin idle_val = '1; step_val = '1; end
                2: begin idle_val = $urandom; step_val = $urandom_range(2000); end
                3: begin idle_val = $urandom_range(100, 1); step_val = '0; end
                default: begin idle_val = 32'd60000; step_val = 32'd500; end
            endcase
            write_config(idle_val, step_val);
            if (phase == 2) begin
                calm         = 1'b1;
                hold_request = 1'b1;
            end
            while (items_sent < 23 + (phase + 1) * PHASE_ITEMS) begin
                if ($urandom_range(9) < 7)
                    run_sweep();
                else
                    run_noise();
            end
            calm = 1'b0;
            drain();
        end

        // tail: turn the block off, then everything goes
        if ($urandom_range(1))
            send_item(MODE_TICK, sb.due_at, 1'b1);
        else
            send_item(MODE_DISABLE, {$urandom, $urandom}, 1'($urandom_range(1)));
        repeat (60) begin
            kind = 2'($urandom_range(MODE_RESERVED));
            if ($urandom_range(1))
                stamp = sb.due_at + 64'($urandom_range(3));
            else
                stamp = {$urandom, $urandom};
            send_item(kind, stamp, 1'($urandom_range(1)));
        end
        drain();
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("idle_tile_refresh_scheduler verification clean");
        else
            $display("idle_tile_refresh_scheduler verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/itrs_pkg.sv
src/itrs_cfg.sv
src/itrs_tile_map.sv
src/itrs_core.sv
src/idle_tile_refresh_scheduler.sv
verif/tb_idle_tile_refresh_scheduler.sv
